// ----- design/irwr_pkg.sv -----
// irwr_pkg: shared types, constants and the bus sequence program
// for the i2c register word reader; no dependencies
`timescale 1ns / 1ps

package irwr_pkg;

	localparam int WORD_BITS = 16;
	localparam int BIT_IDX_W = $clog2(WORD_BITS + 1);
	localparam int TX_BITS   = 8;
	localparam int PROG_LEN  = 76;
	localparam int PC_W      = $clog2(PROG_LEN);
	localparam int CFG_IDX_W = 8;
	localparam int RD_WORD_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = CFG_IDX_W'(1);

	localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h80;
	localparam logic [7:0] HALF_PERIOD_RST    = 8'd20;
	localparam logic [7:0] READ_BIT           = 8'h01;

	typedef enum logic [3:0] {
		OP_SDA_H,
		OP_SDA_L,
		OP_SCL_H,
		OP_SCL_L,
		OP_DLY,
		OP_TXBIT,
		OP_SAMPLE,
		OP_LOAD_W,
		OP_LOAD_P,
		OP_LOAD_R,
		OP_RXINIT,
		OP_LOOPTX,
		OP_ACKCHK,
		OP_LOOPRX,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [PC_W-1:0] tgt;
	} micro_op_t;

	typedef struct packed {
		logic       action;
		logic [7:0] reg_pointer;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_level;
		logic                 busy_res;
		logic                 word_valid;
		logic [RD_WORD_W-1:0] read_word;
	} result_t;

	typedef struct packed {
		logic [7:0] device_address;
		logic [7:0] half_period;
	} cfg_t;

	function automatic micro_op_t mop(op_t op, int tgt);
		micro_op_t m;
		m.op  = op;
		m.tgt = PC_W'(tgt);
		return m;
	endfunction

	// bus sequence: start, write address, pointer, repeated start, read address,
	// data word with ack after the high byte and nack after the last bit, stop
	function automatic micro_op_t prog_rom(logic [PC_W-1:0] pc);
		micro_op_t m;
		unique case (pc)
			7'd0:  m = mop(OP_SDA_H, 0);
			7'd1:  m = mop(OP_SCL_H, 0);
			7'd2:  m = mop(OP_DLY, 0);
			7'd3:  m = mop(OP_SDA_L, 0);
			7'd4:  m = mop(OP_DLY, 0);
			7'd5:  m = mop(OP_SCL_L, 0);
			7'd6:  m = mop(OP_DLY, 0);
			7'd7:  m = mop(OP_LOAD_W, 0);
			7'd8:  m = mop(OP_TXBIT, 0);
			7'd9:  m = mop(OP_SCL_H, 0);
			7'd10: m = mop(OP_DLY, 0);
			7'd11: m = mop(OP_SCL_L, 0);
			7'd12: m = mop(OP_DLY, 0);
			7'd13: m = mop(OP_LOOPTX, 8);
			7'd14: m = mop(OP_SDA_H, 0);
			7'd15: m = mop(OP_SCL_H, 0);
			7'd16: m = mop(OP_DLY, 0);
			7'd17: m = mop(OP_SCL_L, 0);
			7'd18: m = mop(OP_DLY, 0);
			7'd19: m = mop(OP_LOAD_P, 0);
			7'd20: m = mop(OP_TXBIT, 0);
			7'd21: m = mop(OP_SCL_H, 0);
			7'd22: m = mop(OP_DLY, 0);
			7'd23: m = mop(OP_SCL_L, 0);
			7'd24: m = mop(OP_DLY, 0);
			7'd25: m = mop(OP_LOOPTX, 20);
			7'd26: m = mop(OP_SDA_H, 0);
			7'd27: m = mop(OP_SCL_H, 0);
			7'd28: m = mop(OP_DLY, 0);
			7'd29: m = mop(OP_SCL_L, 0);
			7'd30: m = mop(OP_DLY, 0);
			7'd31: m = mop(OP_SDA_H, 0);
			7'd32: m = mop(OP_SCL_H, 0);
			7'd33: m = mop(OP_DLY, 0);
			7'd34: m = mop(OP_SDA_L, 0);
			7'd35: m = mop(OP_DLY, 0);
			7'd36: m = mop(OP_SCL_L, 0);
			7'd37: m = mop(OP_DLY, 0);
			7'd38: m = mop(OP_LOAD_R, 0);
			7'd39: m = mop(OP_TXBIT, 0);
			7'd40: m = mop(OP_SCL_H, 0);
			7'd41: m = mop(OP_DLY, 0);
			7'd42: m = mop(OP_SCL_L, 0);
			7'd43: m = mop(OP_DLY, 0);
			7'd44: m = mop(OP_LOOPTX, 39);
			7'd45: m = mop(OP_SDA_H, 0);
			7'd46: m = mop(OP_SCL_H, 0);
			7'd47: m = mop(OP_DLY, 0);
			7'd48: m = mop(OP_SCL_L, 0);
			7'd49: m = mop(OP_DLY, 0);
			7'd50: m = mop(OP_RXINIT, 0);
			7'd51: m = mop(OP_SDA_H, 0);
			7'd52: m = mop(OP_SCL_H, 0);
			7'd53: m = mop(OP_DLY, 0);
			7'd54: m = mop(OP_SAMPLE, 0);
			7'd55: m = mop(OP_SCL_L, 0);
			7'd56: m = mop(OP_DLY, 0);
			7'd57: m = mop(OP_ACKCHK, 64);
			7'd58: m = mop(OP_SDA_L, 0);
			7'd59: m = mop(OP_SCL_H, 0);
			7'd60: m = mop(OP_DLY, 0);
			7'd61: m = mop(OP_SCL_L, 0);
			7'd62: m = mop(OP_DLY, 0);
			7'd63: m = mop(OP_SDA_H, 0);
			7'd64: m = mop(OP_LOOPRX, 52);
			7'd65: m = mop(OP_SDA_H, 0);
			7'd66: m = mop(OP_SCL_H, 0);
			7'd67: m = mop(OP_DLY, 0);
			7'd68: m = mop(OP_SCL_L, 0);
			7'd69: m = mop(OP_DLY, 0);
			7'd70: m = mop(OP_SDA_L, 0);
			7'd71: m = mop(OP_SCL_H, 0);
			7'd72: m = mop(OP_DLY, 0);
			7'd73: m = mop(OP_SDA_H, 0);
			7'd74: m = mop(OP_DLY, 0);
			default: m = mop(OP_DONE, 0);
		endcase
		return m;
	endfunction

endpackage

// ----- design/irwr_ifs.sv -----
// irwr_ifs: valid/ready channel interfaces for items, results and config writes
// depends on irwr_pkg
`timescale 1ns / 1ps

interface irwr_item_if;
	import irwr_pkg::*;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] reg_pointer;
	logic       sda_in;
	modport source (output valid, action, reg_pointer, sda_in, input ready);
	modport sink (input valid, action, reg_pointer, sda_in, output ready);
endinterface

interface irwr_result_if;
	import irwr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 scl_level;
	logic                 sda_level;
	logic                 busy_res;
	logic                 word_valid;
	logic [RD_WORD_W-1:0] read_word;
	modport source (output valid, scl_level, sda_level, busy_res, word_valid, read_word,
		input ready);
	modport sink (input valid, scl_level, sda_level, busy_res, word_valid, read_word,
		output ready);
endinterface

interface irwr_cfg_if;
	import irwr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/irwr_seq.sv -----
// irwr_seq: bus sequencer state and the one-tick step logic
// depends on irwr_pkg
`timescale 1ns / 1ps

module irwr_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  irwr_pkg::item_t   item,
	input  irwr_pkg::cfg_t    cfg,
	output irwr_pkg::result_t res
);
	import irwr_pkg::*;

	logic                 busy_q, busy_a, busy_n;
	logic [PC_W-1:0]      pc_q, pc_a, pc_t, pc_n;
	logic [BIT_IDX_W-1:0] bit_q, bit_a, bit_n, bit_inc;
	logic [7:0]           cnt_q, cnt_a, cnt_n, dly_base;
	logic [7:0]           tx_q, tx_n;
	logic [WORD_BITS-1:0] rx_q, rx_n;
	logic [7:0]           ptr_q, ptr_n;
	logic                 scl_q, scl_n, sda_q, sda_n;
	logic                 adv, done;
	micro_op_t            top_op, zop, lop;

	always_comb begin
		busy_a = busy_q;
		pc_a   = pc_q;
		bit_a  = bit_q;
		cnt_a  = cnt_q;
		ptr_n  = ptr_q;
		if (!busy_q && item.action) begin
			busy_a = 1'b1;
			pc_a   = '0;
			bit_a  = '0;
			cnt_a  = '0;
			ptr_n  = item.reg_pointer;
		end

		busy_n   = busy_a;
		bit_n    = bit_a;
		cnt_n    = cnt_a;
		tx_n     = tx_q;
		rx_n     = rx_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		done     = 1'b0;
		adv      = 1'b0;
		bit_inc  = bit_a + BIT_IDX_W'(1);
		dly_base = (cnt_a == 8'd0) ? ((cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period)
			: cnt_a;
		top_op   = prog_rom(pc_a);

		// timed pin event
		if (busy_a) begin
			case (top_op.op)
				OP_SDA_H: begin sda_n = 1'b1; adv = 1'b1; end
				OP_SDA_L: begin sda_n = 1'b0; adv = 1'b1; end
				OP_SCL_H: begin scl_n = 1'b1; adv = 1'b1; end
				OP_SCL_L: begin scl_n = 1'b0; adv = 1'b1; end
				OP_TXBIT: begin
					sda_n = tx_q[7];
					tx_n  = {tx_q[6:0], 1'b0};
					adv   = 1'b1;
				end
				OP_SAMPLE: begin
					rx_n = {rx_q[WORD_BITS-2:0], item.sda_in};
					adv  = 1'b1;
				end
				OP_DLY: begin
					cnt_n = dly_base - 8'd1;
					adv   = (cnt_n == 8'd0);
				end
				default: adv = 1'b1;
			endcase
		end

		pc_t = adv ? pc_a + PC_W'(1) : pc_a;
		pc_n = pc_t;
		zop  = prog_rom(pc_t);
		lop  = prog_rom(zop.tgt);

		// zero-time steps that follow the event
		if (busy_a && adv) begin
			case (zop.op)
				OP_LOAD_W: begin
					tx_n  = cfg.device_address;
					bit_n = '0;
					pc_n  = pc_t + PC_W'(1);
				end
				OP_LOAD_P: begin
					tx_n  = ptr_n;
					bit_n = '0;
					pc_n  = pc_t + PC_W'(1);
				end
				OP_LOAD_R: begin
					tx_n  = cfg.device_address | READ_BIT;
					bit_n = '0;
					pc_n  = pc_t + PC_W'(1);
				end
				OP_RXINIT: begin
					rx_n  = '0;
					bit_n = '0;
					pc_n  = pc_t + PC_W'(1);
				end
				OP_LOOPTX: begin
					bit_n = bit_inc;
					pc_n  = (bit_inc < BIT_IDX_W'(TX_BITS)) ? zop.tgt : pc_t + PC_W'(1);
				end
				OP_LOOPRX: begin
					bit_n = bit_inc;
					pc_n  = (bit_inc < BIT_IDX_W'(WORD_BITS)) ? zop.tgt : pc_t + PC_W'(1);
				end
				OP_ACKCHK: begin
					if (bit_a == BIT_IDX_W'(TX_BITS - 1)) begin
						pc_n = pc_t + PC_W'(1);
					end else begin
						bit_n = bit_inc;
						pc_n  = (bit_inc < BIT_IDX_W'(WORD_BITS)) ? lop.tgt
							: zop.tgt + PC_W'(1);
					end
				end
				OP_DONE: begin
					busy_n = 1'b0;
					pc_n   = '0;
					done   = 1'b1;
				end
				default: pc_n = pc_t;
			endcase
		end

		res.scl_level  = scl_n;
		res.sda_level  = sda_n;
		res.busy_res   = busy_n;
		res.word_valid = done;
		res.read_word  = done ? RD_WORD_W'(rx_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			bit_q  <= '0;
			cnt_q  <= '0;
			tx_q   <= '0;
			rx_q   <= '0;
			ptr_q  <= '0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
		end else if (en) begin
			busy_q <= busy_n;
			pc_q   <= pc_n;
			bit_q  <= bit_n;
			cnt_q  <= cnt_n;
			tx_q   <= tx_n;
			rx_q   <= rx_n;
			ptr_q  <= ptr_n;
			scl_q  <= scl_n;
			sda_q  <= sda_n;
		end
	end

endmodule

// ----- design/i2c_register_word_reader.sv -----
// i2c_register_word_reader: tick-driven i2c master that reads one register word
// depends on irwr_pkg, irwr_ifs and irwr_seq
//
// usage: every transaction on item is one bus tick from the time base. a tick
// with action set while idle latches reg_pointer and starts the read: start,
// write address, pointer, repeated start, read address, the data word msb
// first, stop. every accepted tick yields exactly one transaction on result
// with the scl/sda drive levels after that tick and busy_res; word_valid and
// read_word are set on the completing tick only.
// cfg writes device_address (index 0) and half_period (index 1); cfg is
// always ready; the user must keep it written only while the bus is idle;
// the block does not enforce this. a tick passes the input register and
// the sequencer into the output register; one tick is accepted every cycle
// unless result stalls, limited by the sequencer's single step. a stalled
// result stays in the output register, one more tick in the input, then item backs up.
// reset: pins released, sequencer idle, registers at 0x80 and 20.
`timescale 1ns / 1ps

module i2c_register_word_reader (
	input  logic          clk,
	input  logic          arst_n,
	irwr_item_if.sink     item,
	irwr_result_if.source result,
	irwr_cfg_if.sink      cfg
);
	import irwr_pkg::*;

	logic    in_valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q, res_c;
	cfg_t    cfg_q;
	logic    advance;

	assign advance    = in_valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !in_valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= DEVICE_ADDRESS_RST;
			cfg_q.half_period    <= HALF_PERIOD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEVICE_ADDRESS: cfg_q.device_address <= cfg.data;
				REG_HALF_PERIOD:    cfg_q.half_period    <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			in_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.action      <= item.action;
			item_s1.reg_pointer <= item.reg_pointer;
			item_s1.sda_in      <= item.sda_in;
		end
	end

	irwr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.scl_level  = res_q.scl_level;
	assign result.sda_level  = res_q.sda_level;
	assign result.busy_res   = res_q.busy_res;
	assign result.word_valid = res_q.word_valid;
	assign result.read_word  = res_q.read_word;

endmodule

// ----- tb/irwr_read_checker.sv -----
// irwr_read_checker: predicts the pin levels, busy flag and read word of every bus tick
// and compares them with each result transaction; depends on irwr_pkg and irwr_ifs
`timescale 1ns / 1ps

module irwr_read_checker (
	input  logic   clk,
	input  logic   arst_n,
	irwr_item_if   item,
	irwr_result_if result,
	irwr_cfg_if    cfg,
	output int     errors,
	output int     outstanding,
	output logic   reader_busy,
	output int     words_read
);
	import irwr_pkg::*;

	// bus sequence as a list of micro operations with jump targets
	op_t seq_op[$];
	int  seq_tgt[$];

	logic [7:0]  dev_addr;
	logic [7:0]  half_per;
	int          seq_pos;
	int          bit_cnt;
	logic [7:0]  dly_left;
	logic [7:0]  tx_byte;
	logic [31:0] rx_word;
	logic [7:0]  ptr_latch;
	logic        scl;
	logic        sda;
	int          words_done;

	result_t pin_levels_due[$];

	task automatic emit(op_t o, int tgt);
		seq_op.push_back(o);
		seq_tgt.push_back(tgt);
	endtask

	task automatic emit_start();
		emit(OP_SDA_H, 0);
		emit(OP_SCL_H, 0);
		emit(OP_DLY, 0);
		emit(OP_SDA_L, 0);
		emit(OP_DLY, 0);
		emit(OP_SCL_L, 0);
		emit(OP_DLY, 0);
	endtask

	task automatic emit_clock();
		emit(OP_SDA_H, 0);
		emit(OP_SCL_H, 0);
		emit(OP_DLY, 0);
		emit(OP_SCL_L, 0);
		emit(OP_DLY, 0);
	endtask

	task automatic emit_byte(op_t load);
		int top;
		emit(load, 0);
		top = seq_op.size();
		emit(OP_TXBIT, 0);
		emit(OP_SCL_H, 0);
		emit(OP_DLY, 0);
		emit(OP_SCL_L, 0);
		emit(OP_DLY, 0);
		emit(OP_LOOPTX, top);
		emit_clock();
	endtask

	initial begin
		int rx_top;
		int ack_pos;
		emit_start();
		emit_byte(OP_LOAD_W);
		emit_byte(OP_LOAD_P);
		emit_start();
		emit_byte(OP_LOAD_R);
		emit(OP_RXINIT, 0);
		emit(OP_SDA_H, 0);
		rx_top = seq_op.size();
		emit(OP_SCL_H, 0);
		emit(OP_DLY, 0);
		emit(OP_SAMPLE, 0);
		emit(OP_SCL_L, 0);
		emit(OP_DLY, 0);
		ack_pos = seq_op.size();
		emit(OP_ACKCHK, 0);
		emit(OP_SDA_L, 0);
		emit(OP_SCL_H, 0);
		emit(OP_DLY, 0);
		emit(OP_SCL_L, 0);
		emit(OP_DLY, 0);
		emit(OP_SDA_H, 0);
		seq_tgt[ack_pos] = seq_op.size();
		emit(OP_LOOPRX, rx_top);
		emit_clock();
		emit(OP_SDA_L, 0);
		emit(OP_SCL_H, 0);
		emit(OP_DLY, 0);
		emit(OP_SDA_H, 0);
		emit(OP_DLY, 0);
		emit(OP_DONE, 0);
	end

	task automatic clear_model();
		dev_addr   = DEVICE_ADDRESS_RST;
		half_per   = HALF_PERIOD_RST;
		seq_pos    = 0;
		bit_cnt    = 0;
		dly_left   = '0;
		tx_byte    = '0;
		rx_word    = '0;
		ptr_latch  = '0;
		scl        = 1'b1;
		sda        = 1'b1;
		words_done = 0;
	endtask

	// run the operations that take no tick; 1 when the read word is complete
	function automatic bit run_untimed();
		int pc;
		for (int g = 0; g <= seq_op.size(); g++) begin
			if (seq_pos == 0)
				return 1'b0;
			pc = seq_pos - 1;
			if (pc >= seq_op.size()) begin
				seq_pos = 0;
				return 1'b0;
			end
			case (seq_op[pc])
				OP_LOAD_W: begin
					tx_byte = dev_addr;
					bit_cnt = 0;
					seq_pos++;
				end
				OP_LOAD_P: begin
					tx_byte = ptr_latch;
					bit_cnt = 0;
					seq_pos++;
				end
				OP_LOAD_R: begin
					tx_byte = dev_addr | READ_BIT;
					bit_cnt = 0;
					seq_pos++;
				end
				OP_RXINIT: begin
					rx_word = '0;
					bit_cnt = 0;
					seq_pos++;
				end
				OP_LOOPTX: begin
					bit_cnt++;
					seq_pos = (bit_cnt < TX_BITS) ? seq_tgt[pc] + 1 : seq_pos + 1;
				end
				OP_ACKCHK: seq_pos = (bit_cnt == 7) ? seq_pos + 1 : seq_tgt[pc] + 1;
				OP_LOOPRX: begin
					bit_cnt++;
					seq_pos = (bit_cnt < WORD_BITS) ? seq_tgt[pc] + 1 : seq_pos + 1;
				end
				OP_DONE: begin
					seq_pos = 0;
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		end
		return 1'b0;
	endfunction

	function automatic void run_timed(logic sda_bit);
		int pc;
		pc = seq_pos - 1;
		if (pc >= seq_op.size()) begin
			seq_pos = 0;
			return;
		end
		case (seq_op[pc])
			OP_SDA_H: sda = 1'b1;
			OP_SDA_L: sda = 1'b0;
			OP_SCL_H: scl = 1'b1;
			OP_SCL_L: scl = 1'b0;
			OP_TXBIT: begin
				sda     = tx_byte[7];
				tx_byte = tx_byte << 1;
			end
			OP_SAMPLE: rx_word = {rx_word[30:0], sda_bit};
			default: ;
		endcase
		if (seq_op[pc] == OP_DLY) begin
			if (dly_left == 0)
				dly_left = (half_per != 0) ? half_per : 8'd1;
			dly_left--;
			if (dly_left == 0)
				seq_pos++;
		end else begin
			seq_pos++;
		end
	endfunction

	function automatic result_t predict_tick(logic act, logic [7:0] ptr, logic sda_bit);
		result_t r;
		bit done;
		done = 1'b0;
		if (seq_pos == 0 && act) begin
			ptr_latch = ptr;
			bit_cnt   = 0;
			dly_left  = '0;
			seq_pos   = 1;
		end
		if (seq_pos != 0) begin
			done = run_untimed();
			if (!done && seq_pos != 0) begin
				run_timed(sda_bit);
				done = run_untimed();
			end
		end
		if (done)
			words_done++;
		r.scl_level  = scl;
		r.sda_level  = sda;
		r.busy_res   = (seq_pos != 0);
		r.word_valid = done;
		r.read_word  = done ? rx_word[RD_WORD_W-1:0] : '0;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		if (errors < 40)
			$display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			clear_model();
			pin_levels_due.delete();
			errors = 0;
			outstanding <= 0;
			reader_busy <= 1'b0;
			words_read  <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_DEVICE_ADDRESS)
					dev_addr = cfg.data;
				else if (cfg.index == REG_HALF_PERIOD)
					half_per = cfg.data;
			end
			if (item.valid && item.ready)
				pin_levels_due.push_back(predict_tick(item.action, item.reg_pointer,
					item.sda_in));
			if (result.valid && result.ready) begin
				got.scl_level  = result.scl_level;
				got.sda_level  = result.sda_level;
				got.busy_res   = result.busy_res;
				got.word_valid = result.word_valid;
				got.read_word  = result.read_word;
				if (pin_levels_due.size() == 0) begin
					report("unexpected result transaction", 1, 0);
				end else begin
					want = pin_levels_due.pop_front();
					if (got.scl_level !== want.scl_level)
						report("scl_level", got.scl_level, want.scl_level);
					if (got.sda_level !== want.sda_level)
						report("sda_level", got.sda_level, want.sda_level);
					if (got.busy_res !== want.busy_res)
						report("busy_res", got.busy_res, want.busy_res);
					if (got.word_valid !== want.word_valid)
						report("word_valid", got.word_valid, want.word_valid);
					if (got.read_word !== want.read_word)
						report("read_word", got.read_word, want.read_word);
				end
			end
			outstanding <= pin_levels_due.size();
			reader_busy <= (seq_pos != 0);
			words_read  <= words_done;
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: clock, reset and stimulus for i2c_register_word_reader, with irwr_read_checker
// beside it; depends on irwr_pkg, irwr_ifs, the reader and the checker
`timescale 1ns / 1ps

module tb_top;
	import irwr_pkg::*;

	localparam int CYCLE_LIMIT = 20000;
	localparam int SDA_LOW     = 0;
	localparam int SDA_HIGH    = 1;
	localparam int SDA_RANDOM  = 2;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   no_gaps;
	int   cycles = 0;
	int   errors;
	int   outstanding;
	logic reader_busy;
	int   words_read;

	irwr_item_if   item();
	irwr_result_if result();
	irwr_cfg_if    cfg();

	i2c_register_word_reader dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	irwr_read_checker read_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.cfg         (cfg),
		.errors      (errors),
		.outstanding (outstanding),
		.reader_busy (reader_busy),
		.words_read  (words_read)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** i2c_register_word_reader: FAILED **");
			$finish;
		end
	end

	always @(posedge clk)
		result.ready <= no_gaps || ($urandom_range(99) >= 11);

	function automatic logic sda_bit(int mode);
		case (mode)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			default:  return 1'($urandom_range(1));
		endcase
	endfunction

	task automatic send_tick(logic act, logic [7:0] ptr, logic sda_val);
		while (!no_gaps && $urandom_range(99) < 11) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid       <= 1'b1;
		item.action      <= act;
		item.reg_pointer <= ptr;
		item.sda_in      <= sda_val;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
	endtask

	task automatic set_registers(logic [7:0] addr, logic [7:0] hold);
		cfg.valid <= 1'b1;
		cfg.index <= REG_DEVICE_ADDRESS;
		cfg.data  <= addr;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.index <= REG_HALF_PERIOD;
		cfg.data  <= hold;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	// plain ticks until the bus is idle, then drain all results
	task automatic settle_idle();
		do
			send_tick(1'b0, 8'($urandom), sda_bit(SDA_RANDOM));
		while (reader_busy);
		item.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic read_register(logic [7:0] ptr, int mode, bit noise);
		int target;
		send_tick(1'b1, ptr, sda_bit(mode));
		target = words_read + 1;
		while (words_read < target)
			send_tick(noise && $urandom_range(7) == 0, 8'($urandom), sda_bit(mode));
	endtask

	task automatic run_traffic(int n);
		int   target;
		int   mode;
		logic act;
		target = words_read + n;
		mode   = SDA_RANDOM;
		while (words_read < target) begin
			act = ($urandom_range(15) == 0);
			if (act && !reader_busy)
				mode = ($urandom_range(9) < 2) ? $urandom_range(SDA_HIGH) : SDA_RANDOM;
			send_tick(act, 8'($urandom), sda_bit(mode));
		end
	endtask

	initial begin
		item.valid       <= 1'b0;
		item.action      <= 1'b0;
		item.reg_pointer <= '0;
		item.sda_in      <= 1'b0;
		cfg.valid        <= 1'b0;
		cfg.index        <= REG_DEVICE_ADDRESS;
		cfg.data         <= '0;
		no_gaps          <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset device address, all-ones word
		set_registers(DEVICE_ADDRESS_RST, 8'h01);
		read_register(8'h00, SDA_HIGH, 1'b0);
		settle_idle();

		// zero half period behaves as one, all-zeros word, requests while busy
		set_registers(8'h00, 8'h00);
		read_register(8'hFF, SDA_LOW, 1'b1);
		settle_idle();

		set_registers(8'hFE, 8'h03);
		read_register(8'h5A, SDA_RANDOM, 1'b1);
		settle_idle();

		// no idling on either side
		no_gaps <= 1'b1;
		set_registers(8'h81, 8'h02);
		read_register(8'hC3, SDA_RANDOM, 1'b0);
		settle_idle();
		no_gaps <= 1'b0;

		set_registers(8'($urandom_range(254)), 8'($urandom_range(2, 1)));
		run_traffic(1);
		settle_idle();

		repeat (8) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("** i2c_register_word_reader: PASSED **");
		end else begin
			$display("** i2c_register_word_reader: FAILED **");
		end
		$finish;
	end

endmodule
